/* rtl/assert_macros.svh */
// assertion helpers shared by the rtl
// SCC_ASSERT is gated off while reset is low, SCC_ASSERT_ANY is checked at every edge
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
`define SCC_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SCC_ASSERT(lbl, prop, msg)
`define SCC_ASSERT_ANY(lbl, prop, msg)
`endif
`endif

/* rtl/scc_pkg.sv */
// ----------------------------------------------------------------------------
// scc_pkg
// Types and constants for the strongly connected component search engine.
// ----------------------------------------------------------------------------
package scc_pkg;

  localparam int MaxVertices = 64;
  localparam int MaxEdges    = 256;

  // field widths
  localparam int VtxW    = 6;
  localparam int CfgW    = 7;
  localparam int OrdW    = 7;
  localparam int CntW    = $clog2(MaxVertices + 1);
  localparam int DepthAW = $clog2(MaxVertices);
  localparam int EaW     = $clog2(MaxEdges);
  localparam int EdgeW   = EaW + 1;

  // end of list marker
  localparam logic [EdgeW-1:0] EdgeNull = EdgeW'(MaxEdges);

  typedef enum logic [1:0] {
    ActAdd   = 2'd0,
    ActRun   = 2'd1,
    ActClear = 2'd2
  } action_e;

  typedef enum logic [3:0] {
    ScIdle,
    ScAddWr,
    ScRoot,
    ScEnter,
    ScStep,
    ScEdge,
    ScLow,
    ScPop,
    ScCompRd,
    ScComp,
    ScParent,
    ScRestore,
    ScFinish
  } state_e;

  // one search frame: vertex, next edge to follow, discovery order, low link
  typedef struct packed {
    logic [VtxW-1:0]  vtx;
    logic [EdgeW-1:0] nxt;
    logic [OrdW-1:0]  disc;
    logic [OrdW-1:0]  low;
  } frame_t;

  // per-vertex edge list ends
  typedef struct packed {
    logic [EdgeW-1:0] head;
    logic [EdgeW-1:0] tail;
  } list_t;

endpackage

/* rtl/strongly_connected_components.sv */
// ----------------------------------------------------------------------------
// strongly_connected_components
// Loads directed edges into per-vertex lists and runs an iterative Tarjan
// search over them, emitting each component vertex by vertex.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------------------
//  in       | in_valid_i / in_stall_o   | action_i, src_vertex_i, dst_vertex_i
//  out      | out_valid_o / out_stall_i | vertex_o, component_end_o, run_end_o,
//           |                           | overflow_o
//  cfg      | cfg_we_i                  | cfg_data_i (vertex count)
//
// add edge: target write and list read, then the list write and tail link; clear: done in idle.
// run: paced by the registered reads of the edge, list and stack memories.
// one item at a time; in_stall_o is high while an item is being worked.
// a full output stage holds the search until the beat is taken.
// reset clears all control state; no clearing pass is needed.
module strongly_connected_components (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [scc_pkg::CfgW-1:0]      cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    action_i,
  input  logic [scc_pkg::VtxW-1:0]      src_vertex_i,
  input  logic [scc_pkg::VtxW-1:0]      dst_vertex_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [scc_pkg::VtxW-1:0]      vertex_o,
  output logic                          component_end_o,
  output logic                          run_end_o,
  output logic                          overflow_o
);
  import scc_pkg::*;

`include "assert_macros.svh"

  state_e state_q, state_d;

  logic [CfgW-1:0]  vertex_count_q;
  logic [CntW-1:0]  n_w;

  // memories
  logic [VtxW-1:0]  target_mem [MaxEdges];
  logic [EdgeW-1:0] link_mem   [MaxEdges];
  list_t            list_mem   [MaxVertices];
  logic [OrdW-1:0]  disc_mem   [MaxVertices];
  logic [VtxW-1:0]  comp_mem   [MaxVertices];
  frame_t           frame_mem  [MaxVertices];

  logic [VtxW-1:0]  target_rd_q;
  logic [EdgeW-1:0] link_rd_q;
  list_t            list_rd_q;
  logic [OrdW-1:0]  disc_rd_q;
  logic [VtxW-1:0]  comp_rd_q;
  frame_t           frame_rd_q;

  // per-vertex flags
  logic [MaxVertices-1:0] list_vld_q;
  logic [MaxVertices-1:0] visited_q;
  logic [MaxVertices-1:0] onstk_q;

  logic [EdgeW-1:0] fill_q;
  logic             dropped_q;
  logic [OrdW-1:0]  clock_q;
  logic [CntW-1:0]  cdepth_q;
  logic [CntW-1:0]  fdepth_q;
  logic [CntW-1:0]  root_q;
  logic [VtxW-1:0]  vtx_q;
  logic [VtxW-1:0]  src_q;
  frame_t           top_q;

  // output stage and held-back result
  logic             out_valid_q;
  logic [VtxW-1:0]  out_vtx_q;
  logic             out_cend_q;
  logic             out_rend_q;
  logic             out_ovf_q;
  logic             pend_valid_q;
  logic [VtxW-1:0]  pend_vtx_q;
  logic             pend_cend_q;
  logic             out_load;

  // memory strobes
  logic             tgt_we;
  logic             link_we;
  logic [EaW-1:0]   link_wa;
  logic [EdgeW-1:0] link_wd;
  logic             edge_re;
  logic [EaW-1:0]   edge_ra;
  logic             list_we;
  logic [VtxW-1:0]  list_wa;
  list_t            list_wd;
  logic             list_re;
  logic [VtxW-1:0]  list_ra;
  logic             disc_we;
  logic             disc_re;
  logic [VtxW-1:0]  disc_ra;
  logic             comp_we;
  logic             comp_re;
  logic [DepthAW-1:0] comp_ra;
  logic             frame_we;
  logic [DepthAW-1:0] frame_wa;
  logic             frame_re;
  logic [DepthAW-1:0] frame_ra;

  logic             in_acc;
  logic             out_free;
  logic             emit_ok;
  logic             add_ok;
  logic             w_in_range;
  logic             root_live;
  logic             comp_last;
  logic [OrdW-1:0]  clock_inc;
  logic [DepthAW-1:0] root_idx;

  // effective vertex count
  assign n_w = (vertex_count_q > CfgW'(MaxVertices)) ? CntW'(MaxVertices)
                                                    : CntW'(vertex_count_q);

  assign in_stall_o = (state_q != ScIdle);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign emit_ok    = !pend_valid_q || out_free;
  assign add_ok     = (CntW'(src_vertex_i) < n_w) && (CntW'(dst_vertex_i) < n_w) &&
                      (fill_q != EdgeW'(MaxEdges));
  assign w_in_range = CntW'(target_rd_q) < n_w;
  assign root_live  = root_q < n_w;
  assign root_idx   = root_q[DepthAW-1:0];
  assign comp_last  = (comp_rd_q == top_q.vtx);
  assign clock_inc  = clock_q + OrdW'(1);
  assign out_load   = ((state_q == ScComp) && emit_ok && pend_valid_q) ||
                      ((state_q == ScFinish) && pend_valid_q && out_free);

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q <= CfgW'(MaxVertices);
    end else if (cfg_we_i) begin
      vertex_count_q <= cfg_data_i;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ScIdle: begin
        if (in_acc) begin
          unique case (action_i)
            ActAdd:  state_d = add_ok ? ScAddWr : ScIdle;
            ActRun:  state_d = ScRoot;
            default: state_d = ScIdle;
          endcase
        end
      end
      ScAddWr: state_d = ScIdle;
      ScRoot: begin
        if (!root_live) begin
          state_d = ScFinish;
        end else if (!visited_q[root_idx]) begin
          state_d = ScEnter;
        end
      end
      ScEnter: state_d = ScStep;
      ScStep:  state_d = (top_q.nxt == EdgeNull) ? ScPop : ScEdge;
      ScEdge: begin
        priority if (!w_in_range) begin
          state_d = ScStep;
        end else if (!visited_q[target_rd_q]) begin
          state_d = ScEnter;
        end else if (onstk_q[target_rd_q]) begin
          state_d = ScLow;
        end else begin
          state_d = ScStep;
        end
      end
      ScLow:    state_d = ScStep;
      ScPop:    state_d = (top_q.low == top_q.disc) ? ScCompRd : ScParent;
      ScCompRd: state_d = ScComp;
      ScComp: begin
        if (emit_ok) begin
          state_d = comp_last ? ScParent : ScCompRd;
        end
      end
      ScParent:  state_d = (fdepth_q == CntW'(1)) ? ScRoot : ScRestore;
      ScRestore: state_d = ScStep;
      ScFinish: begin
        if (!pend_valid_q || out_free) begin
          state_d = ScIdle;
        end
      end
      default: state_d = ScIdle;
    endcase
  end

  // memory strobes per state
  always_comb begin
    tgt_we   = 1'b0;
    link_we  = 1'b0;
    link_wa  = fill_q[EaW-1:0];
    link_wd  = EdgeNull;
    edge_re  = 1'b0;
    edge_ra  = top_q.nxt[EaW-1:0];
    list_we  = 1'b0;
    list_wa  = src_q;
    list_wd  = '{head: list_vld_q[src_q] ? list_rd_q.head : fill_q, tail: fill_q};
    list_re  = 1'b0;
    list_ra  = src_vertex_i;
    disc_we  = 1'b0;
    disc_re  = 1'b0;
    disc_ra  = target_rd_q;
    comp_we  = 1'b0;
    comp_re  = 1'b0;
    comp_ra  = DepthAW'(cdepth_q - CntW'(1));
    frame_we = 1'b0;
    frame_wa = DepthAW'(fdepth_q - CntW'(1));
    frame_re = 1'b0;
    frame_ra = DepthAW'(fdepth_q - CntW'(2));
    unique case (state_q)
      ScIdle: begin
        if (in_acc && (action_i == ActAdd) && add_ok) begin
          tgt_we  = 1'b1;
          link_we = 1'b1;
          list_re = 1'b1;
        end
      end
      ScAddWr: begin
        list_we = 1'b1;
        if (list_vld_q[src_q]) begin
          link_we = 1'b1;
          link_wa = list_rd_q.tail[EaW-1:0];
          link_wd = fill_q;
        end
      end
      ScRoot: begin
        list_ra = root_idx;
        list_re = root_live && !visited_q[root_idx];
      end
      ScEnter: begin
        disc_we  = 1'b1;
        comp_we  = 1'b1;
        frame_we = (fdepth_q != '0);
      end
      ScStep: edge_re = (top_q.nxt != EdgeNull);
      ScEdge: begin
        list_ra = target_rd_q;
        list_re = w_in_range && !visited_q[target_rd_q];
        disc_re = w_in_range && visited_q[target_rd_q] && onstk_q[target_rd_q];
      end
      ScCompRd: comp_re  = 1'b1;
      ScParent: frame_re = (fdepth_q != CntW'(1));
      default: begin
      end
    endcase
  end

  // edge store
  always_ff @(posedge clk_i) begin
    if (tgt_we) begin
      target_mem[fill_q[EaW-1:0]] <= dst_vertex_i;
    end
    if (edge_re) begin
      target_rd_q <= target_mem[edge_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (edge_re) begin
      link_rd_q <= link_mem[edge_ra];
    end
  end

  // list ends
  always_ff @(posedge clk_i) begin
    if (list_we) begin
      list_mem[list_wa] <= list_wd;
    end
    if (list_re) begin
      list_rd_q <= list_mem[list_ra];
    end
  end

  // discovery order
  always_ff @(posedge clk_i) begin
    if (disc_we) begin
      disc_mem[vtx_q] <= clock_inc;
    end
    if (disc_re) begin
      disc_rd_q <= disc_mem[disc_ra];
    end
  end

  // component stack
  always_ff @(posedge clk_i) begin
    if (comp_we) begin
      comp_mem[cdepth_q[DepthAW-1:0]] <= vtx_q;
    end
    if (comp_re) begin
      comp_rd_q <= comp_mem[comp_ra];
    end
  end

  // frame stack, holds every frame below the top one
  always_ff @(posedge clk_i) begin
    if (frame_we) begin
      frame_mem[frame_wa] <= top_q;
    end
    if (frame_re) begin
      frame_rd_q <= frame_mem[frame_ra];
    end
  end

  // search state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ScIdle;
      list_vld_q <= '0;
      visited_q  <= '0;
      onstk_q    <= '0;
      fill_q     <= '0;
      dropped_q  <= 1'b0;
      clock_q    <= '0;
      cdepth_q   <= '0;
      fdepth_q   <= '0;
      root_q     <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ScIdle: begin
          if (in_acc) begin
            unique case (action_i)
              ActAdd: begin
                if (!add_ok) begin
                  dropped_q <= 1'b1;
                end
              end
              ActRun: begin
                visited_q <= '0;
                onstk_q   <= '0;
                clock_q   <= '0;
                cdepth_q  <= '0;
                fdepth_q  <= '0;
                root_q    <= '0;
              end
              ActClear: begin
                list_vld_q <= '0;
                fill_q     <= '0;
                dropped_q  <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        ScAddWr: begin
          list_vld_q[src_q] <= 1'b1;
          fill_q            <= fill_q + EdgeW'(1);
        end
        ScRoot: begin
          if (root_live && visited_q[root_idx]) begin
            root_q <= root_q + CntW'(1);
          end
        end
        ScEnter: begin
          clock_q          <= clock_inc;
          visited_q[vtx_q] <= 1'b1;
          onstk_q[vtx_q]   <= 1'b1;
          cdepth_q         <= cdepth_q + CntW'(1);
          fdepth_q         <= fdepth_q + CntW'(1);
        end
        ScCompRd: cdepth_q <= cdepth_q - CntW'(1);
        ScComp: begin
          if (emit_ok) begin
            onstk_q[comp_rd_q] <= 1'b0;
          end
        end
        ScParent: fdepth_q <= fdepth_q - CntW'(1);
        default: begin
        end
      endcase
    end
  end

  // payload registers of the search
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ScIdle: begin
        if (in_acc) begin
          src_q <= src_vertex_i;
        end
      end
      ScRoot:  vtx_q <= root_idx;
      ScEnter: begin
        top_q <= '{vtx:  vtx_q,
                   nxt:  list_vld_q[vtx_q] ? list_rd_q.head : EdgeNull,
                   disc: clock_inc,
                   low:  clock_inc};
      end
      ScEdge: begin
        top_q.nxt <= link_rd_q;
        vtx_q     <= target_rd_q;
      end
      ScLow: begin
        if (disc_rd_q < top_q.low) begin
          top_q.low <= disc_rd_q;
        end
      end
      ScRestore: begin
        top_q <= '{vtx:  frame_rd_q.vtx,
                   nxt:  frame_rd_q.nxt,
                   disc: frame_rd_q.disc,
                   low:  (top_q.low < frame_rd_q.low) ? top_q.low : frame_rd_q.low};
      end
      default: begin
      end
    endcase
  end

  // result hold-back: the last beat of a run is only known at the end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if ((state_q == ScComp) && emit_ok) begin
        pend_valid_q <= 1'b1;
      end else if ((state_q == ScFinish) && out_free) begin
        pend_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ScComp) && emit_ok) begin
      pend_vtx_q  <= comp_rd_q;
      pend_cend_q <= comp_last;
      if (pend_valid_q) begin
        out_vtx_q  <= pend_vtx_q;
        out_cend_q <= pend_cend_q;
        out_rend_q <= 1'b0;
        out_ovf_q  <= dropped_q;
      end
    end
    if ((state_q == ScFinish) && pend_valid_q && out_free) begin
      out_vtx_q  <= pend_vtx_q;
      out_cend_q <= pend_cend_q;
      out_rend_q <= 1'b1;
      out_ovf_q  <= dropped_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign vertex_o        = out_vtx_q;
  assign component_end_o = out_cend_q;
  assign run_end_o       = out_rend_q;
  assign overflow_o      = out_ovf_q;

  // checks; the popped frame stays counted while its component drains
  `SCC_ASSERT(a_frames_on_stack, fdepth_q <= cdepth_q + CntW'(1), "more frames than stacked vertices")
  `SCC_ASSERT(a_stack_bound, cdepth_q <= CntW'(MaxVertices), "component stack overrun")
  `SCC_ASSERT(a_emit_holds, ((state_q == ScComp) && emit_ok) |=> pend_valid_q, "result lost")
  `SCC_ASSERT_ANY(a_idle_no_pend, (state_q == ScIdle) |-> !pend_valid_q, "idle with result held")
  `SCC_ASSERT_ANY(a_run_end_comp, (out_valid_q && out_rend_q) |-> out_cend_q, "run end mid component")

endmodule
